>>> rtl/lnrb_pkg.sv
// Shared types and constants of the last-N-lines ring buffer.
package lnrb_pkg;

  // Operation carried by the mode field of an input transaction
  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_EOF  = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  // Configuration port geometry
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned LC_W    = 5;

  // Register index (word address)
  localparam logic [0:0] REG_LINE_COUNT = 1'b0;

  localparam logic [LC_W-1:0] LINE_COUNT_RST = 5'd10;
  localparam logic [7:0]      NEWLINE        = 8'd10;

  // Flags of a result on its way to the output register
  typedef struct packed {
    logic done;
    logic line_end;
    logic trunc;
    logic from_mem;
  } res_t;

endpackage

>>> rtl/lnrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lnrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/last_n_lines_ring_buffer_unit.sv
// Top level: keeps the most recent lines of a byte stream and replays them oldest first.
//
// Text bytes pushed in are stored in a byte RAM laid out as MAX_LINES slots of
// 2**ceil(log2(LINE_CHARS)) bytes; per-slot line lengths live in flip-flops
// and reset to empty, so no clearing pass is needed after reset. A push or an
// end-of-input transaction can be accepted every cycle, even while a result
// waits at the output. A read transaction issues one RAM read; its flags wait
// in the pending register for the RAM's registered read data, and both then
// go into the output register. A new read is accepted only while the pending
// register is empty and the output register is free. Reads touch the RAM only
// after end of input, when writing has stopped, so reads and writes never hit
// the same entry at once. Lines longer than LINE_CHARS are cut and flagged in
// truncated_seen_o. line_count (register 0, reset 10) must be written over the
// APB port only while the block is idle; the block does not enforce this.
module last_n_lines_ring_buffer_unit #(
  parameter int unsigned MAX_LINES  = 16,
  parameter int unsigned LINE_CHARS = 4095
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       mode_i,
  input  logic [7:0]                       data_byte_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       out_byte_o,
  output logic                             line_end_o,
  output logic                             done_res_o,
  output logic                             truncated_seen_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lnrb_pkg::PADDR_W-1:0]     paddr,
  input  logic [lnrb_pkg::APB_DW-1:0]      pwdata,
  output logic [lnrb_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned SLOT_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_LINES + 1);
  localparam int unsigned COL_W     = $clog2(LINE_CHARS);
  localparam int unsigned LEN_W     = $clog2(LINE_CHARS + 1);
  localparam int unsigned EFF_W     = (CNT_W > lnrb_pkg::LC_W) ? CNT_W : lnrb_pkg::LC_W;
  localparam int unsigned MEM_DEPTH = MAX_LINES * (2 ** COL_W);
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_CHARS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LINE_CHARS);

  // ring state
  logic [lnrb_pkg::LC_W-1:0] line_count_q;
  logic [LEN_W-1:0]  slot_len_q [MAX_LINES];
  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic              full_q, full_d;
  logic [LEN_W-1:0]  write_col_q, write_col_d;
  logic              ovf_q, ovf_d;
  logic              reading_q, reading_d;
  logic [SLOT_W-1:0] read_slot_q, read_slot_d;
  logic [LEN_W-1:0]  read_col_q, read_col_d;
  logic [CNT_W-1:0]  lines_read_q, lines_read_d;
  logic              warned_q, warned_d;

  // result path
  logic              pend_q, pend_d;
  lnrb_pkg::res_t    pend_res_q, pend_res_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q;
  lnrb_pkg::res_t    out_res_q;

  // memory port
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // commit
  logic              commit_en;
  logic [LEN_W-1:0]  commit_len;
  logic [CNT_W-1:0]  ws_inc;
  logic              ws_wrap;
  logic [SLOT_W-1:0] com_ws, com_oldest, rs_src;

  logic [EFF_W-1:0]  lc_ext, eff_wide;
  logic [CNT_W-1:0]  eff;
  logic              in_accept, is_read, out_load;
  logic              cfg_we;
  logic [LEN_W-1:0]  wc_inc, rc_inc, cur_len;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0]  cnt);
    logic [CNT_W-1:0] t;
    t = CNT_W'(s) + CNT_W'(1);
    return (t >= cnt) ? '0 : t[SLOT_W-1:0];
  endfunction

  // effective line count, clamped to 1..MAX_LINES
  always_comb begin
    lc_ext   = EFF_W'(line_count_q);
    eff_wide = (lc_ext == '0) ? EFF_W'(1) :
               (lc_ext > EFF_W'(MAX_LINES)) ? EFF_W'(MAX_LINES) : lc_ext;
    eff      = CNT_W'(eff_wide);
  end

  // ring pointers after a line commit
  always_comb begin
    ws_inc     = CNT_W'(write_slot_q) + CNT_W'(1);
    ws_wrap    = (ws_inc >= eff);
    com_ws     = ws_wrap ? '0 : ws_inc[SLOT_W-1:0];
    com_oldest = full_q ? next_slot(oldest_q, eff) : oldest_q;
  end

  // handshake
  assign is_read    = (mode_i == lnrb_pkg::MODE_READ);
  assign in_ready_o = is_read ? (!pend_q && (!out_valid_q || out_ready_i)) : 1'b1;
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_load   = pend_q && (!out_valid_q || out_ready_i);

  assign wc_inc  = write_col_q + LEN_W'(1);
  assign rc_inc  = read_col_q + LEN_W'(1);
  assign cur_len = slot_len_q[read_slot_q];

  // transaction processing
  always_comb begin
    oldest_d     = oldest_q;
    write_slot_d = write_slot_q;
    full_d       = full_q;
    write_col_d  = write_col_q;
    ovf_d        = ovf_q;
    reading_d    = reading_q;
    read_slot_d  = read_slot_q;
    read_col_d   = read_col_q;
    lines_read_d = lines_read_q;
    warned_d     = warned_q;
    commit_en    = 1'b0;
    commit_len   = write_col_q;
    rs_src       = oldest_q;
    mem_we       = 1'b0;
    mem_waddr    = MEM_AW'({write_slot_q, write_col_q[COL_W-1:0]});
    mem_wdata    = data_byte_i;
    mem_re       = 1'b0;
    mem_raddr    = MEM_AW'({read_slot_q, read_col_q[COL_W-1:0]});
    pend_res_d   = pend_res_q;
    pend_d       = pend_q && !out_load;

    if (in_accept) begin
      unique case (mode_i)
        lnrb_pkg::MODE_PUSH: begin
          if (!reading_q) begin
            if (ovf_q) begin
              // overlong line: a newline lands in the last column
              if (data_byte_i == lnrb_pkg::NEWLINE) begin
                mem_we      = 1'b1;
                mem_waddr   = MEM_AW'({write_slot_q, LAST_COL});
                commit_en   = 1'b1;
                commit_len  = LEN_MAX;
                write_col_d = '0;
                ovf_d       = 1'b0;
              end
            end else begin
              mem_we = 1'b1;
              if (data_byte_i == lnrb_pkg::NEWLINE) begin
                commit_en   = 1'b1;
                commit_len  = wc_inc;
                write_col_d = '0;
              end else begin
                write_col_d = wc_inc;
                if (wc_inc >= LEN_MAX) begin
                  ovf_d    = 1'b1;
                  warned_d = 1'b1;
                end
              end
            end
          end
        end
        lnrb_pkg::MODE_EOF: begin
          if (!reading_q) begin
            if (write_col_q != '0) begin
              commit_en = 1'b1;
            end
            rs_src       = commit_en ? com_oldest : oldest_q;
            write_col_d  = '0;
            ovf_d        = 1'b0;
            reading_d    = 1'b1;
            read_slot_d  = (CNT_W'(rs_src) < eff) ? rs_src : '0;
            read_col_d   = '0;
            lines_read_d = '0;
          end
        end
        lnrb_pkg::MODE_READ: begin
          pend_d              = 1'b1;
          pend_res_d.done     = 1'b1;
          pend_res_d.line_end = 1'b0;
          pend_res_d.trunc    = warned_q;
          pend_res_d.from_mem = 1'b0;
          if (reading_q && (lines_read_q < eff) && (cur_len != '0) &&
              (read_col_q < cur_len)) begin
            mem_re              = 1'b1;
            pend_res_d.done     = 1'b0;
            pend_res_d.from_mem = 1'b1;
            read_col_d          = rc_inc;
            if (rc_inc >= cur_len) begin
              pend_res_d.line_end = 1'b1;
              read_col_d          = '0;
              lines_read_d        = lines_read_q + CNT_W'(1);
              read_slot_d         = next_slot(read_slot_q, eff);
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (commit_en) begin
      write_slot_d = com_ws;
      full_d       = full_q | ws_wrap;
      oldest_d     = com_oldest;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  lnrb_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // configuration port
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[lnrb_pkg::PADDR_W-1:2] == lnrb_pkg::REG_LINE_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr[lnrb_pkg::PADDR_W-1:2] == lnrb_pkg::REG_LINE_COUNT) ?
                  lnrb_pkg::APB_DW'(line_count_q) : '0;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= lnrb_pkg::LINE_COUNT_RST;
      for (int i = 0; i < MAX_LINES; i++) begin
        slot_len_q[i] <= '0;
      end
      oldest_q     <= '0;
      write_slot_q <= '0;
      full_q       <= 1'b0;
      write_col_q  <= '0;
      ovf_q        <= 1'b0;
      reading_q    <= 1'b0;
      read_slot_q  <= '0;
      read_col_q   <= '0;
      lines_read_q <= '0;
      warned_q     <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_count_q <= pwdata[lnrb_pkg::LC_W-1:0];
      end
      if (commit_en) begin
        slot_len_q[write_slot_q] <= commit_len;
      end
      oldest_q     <= oldest_d;
      write_slot_q <= write_slot_d;
      full_q       <= full_d;
      write_col_q  <= write_col_d;
      ovf_q        <= ovf_d;
      reading_q    <= reading_d;
      read_slot_q  <= read_slot_d;
      read_col_q   <= read_col_d;
      lines_read_q <= lines_read_d;
      warned_q     <= warned_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pend_res_q <= pend_res_d;
    if (out_load) begin
      out_res_q  <= pend_res_q;
      out_byte_q <= pend_res_q.from_mem ? mem_rdata : 8'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign line_end_o       = out_res_q.line_end;
  assign done_res_o       = out_res_q.done;
  assign truncated_seen_o = out_res_q.trunc;

endmodule

>>> rtl/lnrb_checker.sv
// Port-level checker for the ring buffer top level, with its bind.
module lnrb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [1:0]                   mode_i,
  input logic [7:0]                   data_byte_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [7:0]                   out_byte_o,
  input logic                         line_end_o,
  input logic                         done_res_o,
  input logic                         truncated_seen_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [lnrb_pkg::PADDR_W-1:0] paddr,
  input logic [lnrb_pkg::APB_DW-1:0]  pwdata,
  input logic [lnrb_pkg::APB_DW-1:0]  prdata,
  input logic                         pready
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result withdrawn before transaction");

  // a done result carries no byte and no line end
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (out_byte_o == 8'd0 && !line_end_o))
    else $error("done result with payload");

  // every accepted read shows a valid result after the pending and output registers
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == lnrb_pkg::MODE_READ) |=> ##1 out_valid_o)
    else $error("read result missing");

  // line_count reads back what was written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready &&
     paddr[lnrb_pkg::PADDR_W-1:2] == lnrb_pkg::REG_LINE_COUNT)
    |=> (paddr[lnrb_pkg::PADDR_W-1:2] != lnrb_pkg::REG_LINE_COUNT ||
         prdata[lnrb_pkg::LC_W-1:0] == $past(pwdata[lnrb_pkg::LC_W-1:0])))
    else $error("line_count readback mismatch");

endmodule

bind last_n_lines_ring_buffer_unit lnrb_checker u_lnrb_checker (.*);
